// ===== rtl/float_cosine_similarity_top_assert.svh =====
// Assertion macros for the cosine similarity block.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef FLOAT_COSINE_SIMILARITY_TOP_ASSERT_SVH
`define FLOAT_COSINE_SIMILARITY_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FCS_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fcs: same-cycle check failed");
`define FCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fcs: next-cycle check failed");
`else
`define FCS_ASSERT_IMPLIES(lbl, ante, cons)
`define FCS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/fcs_pkg.sv =====
package fcs_pkg;

    localparam int MANT_W = 51;
    localparam int EXP_W  = 12;

    typedef logic [MANT_W-1:0]       t_mant;
    typedef logic signed [EXP_W-1:0] t_exp;

    typedef logic [1:0] t_fop;
    localparam t_fop FOP_MUL = 2'd0;
    localparam t_fop FOP_ADD = 2'd1;
    localparam t_fop FOP_RND = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam t_exp        EXP_BIAS  = 12'sd127;

    function automatic logic f_is_nan(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic f_is_inf(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
    endfunction

    function automatic logic f_is_zero(input logic [31:0] v);
        return v[30:0] == 31'd0;
    endfunction

    // Significand with the hidden bit; subnormals have it clear.
    function automatic logic [23:0] f_mant(input logic [31:0] v);
        return {v[30:23] != 8'd0, v[22:0]};
    endfunction

    // Biased exponent, with subnormals placed at exponent one.
    function automatic t_exp f_bexp(input logic [31:0] v);
        return (v[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, v[30:23]});
    endfunction

endpackage

// ===== rtl/fcs_fpu.sv =====
module fcs_fpu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  fcs_pkg::t_fop      i_op,
    input  logic [31:0]        i_a,
    input  logic [31:0]        i_b,
    input  logic               i_sign,
    input  fcs_pkg::t_exp      i_exp,
    input  fcs_pkg::t_mant     i_mant,
    output fcs_pkg::t_unit_stat o_stat,
    output logic [31:0]        o_result
);
    import fcs_pkg::*;

    localparam logic [1:0] FS_IDLE  = 2'd0;
    localparam logic [1:0] FS_NORM  = 2'd1;
    localparam logic [1:0] FS_ROUND = 2'd2;

    logic [1:0]  r_state, n_state;
    logic        r_done, n_done;
    logic        r_s, n_s;
    t_exp        r_x, n_x;
    t_mant       r_m, n_m;
    logic [31:0] r_res, n_res;

    // Multiply setup.
    logic [47:0] mul_p;
    t_exp        mul_x;
    logic        mul_sgn;

    // Add setup: the larger magnitude is kept, the smaller is aligned with sticky.
    logic        add_swap;
    logic [31:0] add_big, add_sml;
    t_exp        add_d;
    t_mant       add_mb, add_ms, add_shifted, add_op, add_sum;
    logic [5:0]  add_sh;
    logic        add_far, add_st, add_sub, add_sgn;

    logic        l_spec;
    logic [31:0] l_spec_bits;
    logic        l_s;
    t_exp        l_x;
    t_mant       l_m;

    // Rounding and packing.
    logic [23:0] rd_keep, rd_frac;
    logic [24:0] rd_sum;
    logic        rd_g, rd_st, rd_up, rd_carry;
    t_exp        rd_x;
    logic [31:0] rd_bits;

    assign mul_p   = {24'd0, f_mant(i_a)} * {24'd0, f_mant(i_b)};
    assign mul_x   = f_bexp(i_a) + f_bexp(i_b) - EXP_BIAS;
    assign mul_sgn = i_a[31] ^ i_b[31];

    assign add_swap    = i_b[30:0] > i_a[30:0];
    assign add_big     = add_swap ? i_b : i_a;
    assign add_sml     = add_swap ? i_a : i_b;
    assign add_d       = f_bexp(add_big) - f_bexp(add_sml);
    assign add_mb      = {1'b0, f_mant(add_big), 26'd0};
    assign add_ms      = {1'b0, f_mant(add_sml), 26'd0};
    assign add_far     = add_d > 12'sd50;
    assign add_sh      = add_d[5:0];
    assign add_shifted = add_far ? '0 : (add_ms >> add_sh);
    assign add_st      = add_far ? (add_ms != '0)
                                 : ((add_ms & ~({MANT_W{1'b1}} << add_sh)) != '0);
    assign add_op      = add_shifted | {{(MANT_W-1){1'b0}}, add_st};
    assign add_sub     = i_a[31] ^ i_b[31];
    assign add_sum     = add_sub ? (add_mb - add_op) : (add_mb + add_op);
    // An exact zero sum is positive unless both operands are negative.
    assign add_sgn     = (add_sum == '0) ? (i_a[31] & i_b[31]) : add_big[31];

    always_comb begin
        l_spec      = 1'b0;
        l_spec_bits = QNAN_BITS;
        l_s         = 1'b0;
        l_x         = '0;
        l_m         = '0;
        case (i_op)
            FOP_MUL: begin
                l_s = mul_sgn;
                l_x = mul_x;
                l_m = {mul_p, 3'd0};
                if (f_is_nan(i_a) || f_is_nan(i_b)) begin
                    l_spec = 1'b1;
                end else if ((f_is_inf(i_a) && f_is_zero(i_b)) ||
                             (f_is_zero(i_a) && f_is_inf(i_b))) begin
                    l_spec = 1'b1;
                end else if (f_is_inf(i_a) || f_is_inf(i_b)) begin
                    l_spec      = 1'b1;
                    l_spec_bits = {mul_sgn, 8'hFF, 23'd0};
                end else if (f_is_zero(i_a) || f_is_zero(i_b)) begin
                    l_spec      = 1'b1;
                    l_spec_bits = {mul_sgn, 31'd0};
                end
            end
            FOP_ADD: begin
                l_s = add_sgn;
                l_x = f_bexp(add_big);
                l_m = add_sum;
                if (f_is_nan(i_a) || f_is_nan(i_b)) begin
                    l_spec = 1'b1;
                end else if (f_is_inf(i_a) && f_is_inf(i_b) && add_sub) begin
                    l_spec = 1'b1;
                end else if (f_is_inf(i_a)) begin
                    l_spec      = 1'b1;
                    l_spec_bits = i_a;
                end else if (f_is_inf(i_b)) begin
                    l_spec      = 1'b1;
                    l_spec_bits = i_b;
                end
            end
            FOP_RND: begin
                l_s = i_sign;
                l_x = i_exp;
                l_m = i_mant;
            end
            default: begin
                l_spec = 1'b1;
            end
        endcase
    end

    assign rd_keep  = r_m[49:26];
    assign rd_g     = r_m[25];
    assign rd_st    = |r_m[24:0];
    assign rd_up    = rd_g & (rd_st | rd_keep[0]);
    assign rd_sum   = {1'b0, rd_keep} + {24'd0, rd_up};
    assign rd_carry = rd_sum[24];
    assign rd_frac  = rd_carry ? rd_sum[24:1] : rd_sum[23:0];
    assign rd_x     = r_x + $signed({11'd0, rd_carry});
    assign rd_bits  = (rd_x >= 12'sd255) ? {r_s, 8'hFF, 23'd0}
                    : {r_s, (rd_frac[23] ? rd_x[7:0] : 8'd0), rd_frac[22:0]};

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_s     = r_s;
        n_x     = r_x;
        n_m     = r_m;
        n_res   = r_res;
        case (r_state)
            FS_IDLE: begin
                if (i_start) begin
                    if (l_spec) begin
                        n_res  = l_spec_bits;
                        n_done = 1'b1;
                    end else begin
                        n_s     = l_s;
                        n_x     = l_x;
                        n_m     = l_m;
                        n_state = FS_NORM;
                    end
                end
            end
            FS_NORM: begin
                // One bit of normalization per cycle; results below the normal
                // range are shifted right to exponent one to form subnormals.
                if (r_m == '0) begin
                    n_state = FS_ROUND;
                end else if (r_m[MANT_W-1] || (r_x < 12'sd1)) begin
                    n_m = {1'b0, r_m[MANT_W-1:2], r_m[1] | r_m[0]};
                    n_x = r_x + 12'sd1;
                end else if (!r_m[MANT_W-2] && (r_x > 12'sd1)) begin
                    n_m = {r_m[MANT_W-2:0], 1'b0};
                    n_x = r_x - 12'sd1;
                end else begin
                    n_state = FS_ROUND;
                end
            end
            FS_ROUND: begin
                n_res   = rd_bits;
                n_done  = 1'b1;
                n_state = FS_IDLE;
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s   <= n_s;
        r_x   <= n_x;
        r_m   <= n_m;
        r_res <= n_res;
    end

    assign o_stat.busy = r_state != FS_IDLE;
    assign o_stat.done = r_done;
    assign o_result    = r_res;

endmodule

// ===== rtl/fcs_dsu.sv =====
module fcs_dsu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_sqrt,
    input  logic [31:0]         i_a,
    input  logic [31:0]         i_b,
    output fcs_pkg::t_unit_stat o_stat,
    output logic                o_special,
    output logic [31:0]         o_bits,
    output logic                o_sign,
    output fcs_pkg::t_exp       o_exp,
    output fcs_pkg::t_mant      o_mant
);
    import fcs_pkg::*;

    localparam logic [1:0] DS_IDLE = 2'd0;
    localparam logic [1:0] DS_NORM = 2'd1;
    localparam logic [1:0] DS_ITER = 2'd2;
    localparam logic [1:0] DS_DONE = 2'd3;

    localparam int RW    = 29;
    localparam int QW    = 27;
    localparam int CW    = 5;
    localparam int RAD_W = 52;

    logic [1:0]       r_state, n_state;
    logic             r_sqrt, n_sqrt;
    logic             r_special, n_special;
    logic [31:0]      r_bits, n_bits;
    logic             r_sign, n_sign;
    logic [23:0]      r_ma, n_ma, r_mb, n_mb;
    t_exp             r_ua, n_ua, r_ub, n_ub, r_x, n_x;
    logic [RAD_W-1:0] r_rad, n_rad;
    logic [RW-1:0]    r_rem, n_rem;
    logic [QW-1:0]    r_q, n_q;
    logic [CW-1:0]    r_cnt, n_cnt;

    logic             st_spec;
    logic [31:0]      st_bits;
    logic             st_sign;

    logic [RW-1:0]    it_rp, it_cmp, it_t, it_diff, it_keep;
    logic             it_ge;
    logic             sticky;

    assign st_sign = i_sqrt ? 1'b0 : (i_a[31] ^ i_b[31]);

    always_comb begin
        st_spec = 1'b0;
        st_bits = QNAN_BITS;
        if (i_sqrt) begin
            if (f_is_nan(i_a)) begin
                st_spec = 1'b1;
            end else if (f_is_zero(i_a)) begin
                st_spec = 1'b1;
                st_bits = i_a;
            end else if (i_a[31]) begin
                st_spec = 1'b1;
            end else if (f_is_inf(i_a)) begin
                st_spec = 1'b1;
                st_bits = i_a;
            end
        end else begin
            if (f_is_nan(i_a) || f_is_nan(i_b)) begin
                st_spec = 1'b1;
            end else if ((f_is_inf(i_a) && f_is_inf(i_b)) ||
                         (f_is_zero(i_a) && f_is_zero(i_b))) begin
                st_spec = 1'b1;
            end else if (f_is_inf(i_a) || f_is_zero(i_b)) begin
                st_spec = 1'b1;
                st_bits = {st_sign, 8'hFF, 23'd0};
            end else if (f_is_zero(i_a) || f_is_inf(i_b)) begin
                st_spec = 1'b1;
                st_bits = {st_sign, 31'd0};
            end
        end
    end

    // One compare-subtract serves both recurrences: two radicand bits per
    // step for the root, one quotient bit per step for the division.
    assign it_rp   = {r_rem[RW-3:0], r_rad[RAD_W-1:RAD_W-2]};
    assign it_cmp  = r_sqrt ? it_rp : r_rem;
    assign it_t    = r_sqrt ? {r_q, 2'b01} : {5'd0, r_mb};
    assign it_ge   = it_cmp >= it_t;
    assign it_diff = it_cmp - it_t;
    assign it_keep = it_ge ? it_diff : it_cmp;

    always_comb begin
        n_state   = r_state;
        n_sqrt    = r_sqrt;
        n_special = r_special;
        n_bits    = r_bits;
        n_sign    = r_sign;
        n_ma      = r_ma;
        n_mb      = r_mb;
        n_ua      = r_ua;
        n_ub      = r_ub;
        n_x       = r_x;
        n_rad     = r_rad;
        n_rem     = r_rem;
        n_q       = r_q;
        n_cnt     = r_cnt;
        case (r_state)
            DS_IDLE: begin
                if (i_start) begin
                    n_sqrt    = i_sqrt;
                    n_special = st_spec;
                    n_bits    = st_bits;
                    n_sign    = st_sign;
                    n_ma      = f_mant(i_a);
                    n_ua      = f_bexp(i_a) - EXP_BIAS;
                    n_mb      = i_sqrt ? 24'h80_0000 : f_mant(i_b);
                    n_ub      = i_sqrt ? '0 : (f_bexp(i_b) - EXP_BIAS);
                    n_state   = st_spec ? DS_DONE : DS_NORM;
                end
            end
            DS_NORM: begin
                if (!r_ma[23]) begin
                    n_ma = {r_ma[22:0], 1'b0};
                    n_ua = r_ua - 12'sd1;
                end else if (!r_mb[23]) begin
                    n_mb = {r_mb[22:0], 1'b0};
                    n_ub = r_ub - 12'sd1;
                end else begin
                    // An odd exponent moves one bit into the radicand.
                    n_rad   = r_ua[0] ? {r_ma, 28'd0} : {1'b0, r_ma, 27'd0};
                    n_rem   = r_sqrt ? '0 : {5'd0, r_ma};
                    n_q     = '0;
                    n_cnt   = r_sqrt ? CW'(26) : CW'(27);
                    n_x     = r_sqrt ? ((r_ua >>> 1) + EXP_BIAS) : (r_ua - r_ub + EXP_BIAS);
                    n_state = DS_ITER;
                end
            end
            DS_ITER: begin
                n_q   = {r_q[QW-2:0], it_ge};
                n_rem = r_sqrt ? it_keep : {it_keep[RW-2:0], 1'b0};
                n_rad = {r_rad[RAD_W-3:0], 2'b00};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = DS_DONE;
                end
            end
            DS_DONE: begin
                n_state = DS_IDLE;
            end
            default: begin
                n_state = DS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sqrt    <= n_sqrt;
        r_special <= n_special;
        r_bits    <= n_bits;
        r_sign    <= n_sign;
        r_ma      <= n_ma;
        r_mb      <= n_mb;
        r_ua      <= n_ua;
        r_ub      <= n_ub;
        r_x       <= n_x;
        r_rad     <= n_rad;
        r_rem     <= n_rem;
        r_q       <= n_q;
        r_cnt     <= n_cnt;
    end

    assign sticky      = r_rem != '0;
    assign o_stat.busy = r_state != DS_IDLE;
    assign o_stat.done = r_state == DS_DONE;
    assign o_special   = r_special;
    assign o_bits      = r_bits;
    assign o_sign      = r_sign;
    assign o_exp       = r_x;
    assign o_mant      = r_sqrt ? {1'b0, r_q[25:0], 23'd0, sticky}
                                : {1'b0, r_q, 22'd0, sticky};

endmodule

// ===== rtl/float_cosine_similarity_top.sv =====
// Streaming float32 cosine similarity. Each input beat carries one element pair; the block
// folds it into the dot product and both squared norms in index order, with every multiply
// and add rounded to nearest-even on one shared multiply/add/round unit. A non-last beat
// runs six operations on that unit, each taking longer the more normalizing shifts it
// needs, so subnormal operands and heavy cancellation slow a beat down; the input stalls
// meanwhile. On the last beat two square roots (one root bit per cycle), a multiply
// and a division (one quotient bit per cycle) follow. A zero norm gives the quiet NaN
// 0x7FC00000 with zero_norm set; any other NaN result is also returned as 0x7FC00000.
// The result sits in an output register, so the next vector may start while it waits.
`include "float_cosine_similarity_top_assert.svh"

module float_cosine_similarity_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_a_elem,
    input  logic [31:0] i_b_elem,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_similarity,
    output logic        o_zero_norm
);
    import fcs_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MUL_AB  = 4'd1;
    localparam logic [3:0] S_ADD_DOT = 4'd2;
    localparam logic [3:0] S_MUL_AA  = 4'd3;
    localparam logic [3:0] S_ADD_NA  = 4'd4;
    localparam logic [3:0] S_MUL_BB  = 4'd5;
    localparam logic [3:0] S_ADD_NB  = 4'd6;
    localparam logic [3:0] S_CHECK   = 4'd7;
    localparam logic [3:0] S_SQ_A    = 4'd8;
    localparam logic [3:0] S_RND_A   = 4'd9;
    localparam logic [3:0] S_SQ_B    = 4'd10;
    localparam logic [3:0] S_RND_B   = 4'd11;
    localparam logic [3:0] S_MUL_DEN = 4'd12;
    localparam logic [3:0] S_DIV     = 4'd13;
    localparam logic [3:0] S_RND_Q   = 4'd14;
    localparam logic [3:0] S_OUT     = 4'd15;

    logic [3:0]  r_state, n_state;
    logic        r_go, n_go;
    logic [31:0] r_a, n_a, r_b, n_b;
    logic        r_last, n_last;
    logic [31:0] r_p, n_p;
    logic [31:0] r_dot, n_dot, r_na, n_na, r_nb, n_nb;
    logic [31:0] r_sqa, n_sqa, r_sqb, n_sqb, r_den, n_den, r_q, n_q;
    logic        r_zf, n_zf;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_sim, n_out_sim;
    logic        r_out_zero, n_out_zero;

    logic        fpu_state, fpu_start;
    t_fop        fpu_op;
    logic [31:0] fpu_a, fpu_b, fpu_res;
    t_unit_stat  fpu_stat;

    logic        ds_state, ds_start, ds_sqrt, ds_special, ds_sign;
    logic [31:0] ds_a, ds_bits;
    t_exp        ds_exp;
    t_mant       ds_mant;
    t_unit_stat  ds_stat;

    logic        out_free, in_beat;

    assign fpu_state = (r_state == S_MUL_AB) || (r_state == S_ADD_DOT) ||
                       (r_state == S_MUL_AA) || (r_state == S_ADD_NA) ||
                       (r_state == S_MUL_BB) || (r_state == S_ADD_NB) ||
                       (r_state == S_RND_A) || (r_state == S_RND_B) ||
                       (r_state == S_MUL_DEN) || (r_state == S_RND_Q);
    assign ds_state  = (r_state == S_SQ_A) || (r_state == S_SQ_B) || (r_state == S_DIV);
    assign fpu_start = r_go && fpu_state;
    assign ds_start  = r_go && ds_state;
    assign ds_sqrt   = r_state != S_DIV;
    assign ds_a      = (r_state == S_SQ_A) ? r_na : ((r_state == S_SQ_B) ? r_nb : r_dot);

    always_comb begin
        fpu_op = FOP_MUL;
        fpu_a  = r_a;
        fpu_b  = r_b;
        case (r_state)
            S_ADD_DOT: begin
                fpu_op = FOP_ADD;
                fpu_a  = r_dot;
                fpu_b  = r_p;
            end
            S_MUL_AA: begin
                fpu_b = r_a;
            end
            S_ADD_NA: begin
                fpu_op = FOP_ADD;
                fpu_a  = r_na;
                fpu_b  = r_p;
            end
            S_MUL_BB: begin
                fpu_a = r_b;
            end
            S_ADD_NB: begin
                fpu_op = FOP_ADD;
                fpu_a  = r_nb;
                fpu_b  = r_p;
            end
            S_MUL_DEN: begin
                fpu_a = r_sqa;
                fpu_b = r_sqb;
            end
            S_RND_A, S_RND_B, S_RND_Q: begin
                fpu_op = FOP_RND;
            end
            default: begin
                fpu_op = FOP_MUL;
            end
        endcase
    end

    fcs_fpu u_fpu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (fpu_start),
        .i_op     (fpu_op),
        .i_a      (fpu_a),
        .i_b      (fpu_b),
        .i_sign   (ds_sign),
        .i_exp    (ds_exp),
        .i_mant   (ds_mant),
        .o_stat   (fpu_stat),
        .o_result (fpu_res)
    );

    fcs_dsu u_dsu (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (ds_start),
        .i_sqrt    (ds_sqrt),
        .i_a       (ds_a),
        .i_b       (r_den),
        .o_stat    (ds_stat),
        .o_special (ds_special),
        .o_bits    (ds_bits),
        .o_sign    (ds_sign),
        .o_exp     (ds_exp),
        .o_mant    (ds_mant)
    );

    assign o_in_stall = r_state != S_IDLE;
    assign in_beat    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_go        = 1'b0;
        n_a         = r_a;
        n_b         = r_b;
        n_last      = r_last;
        n_p         = r_p;
        n_dot       = r_dot;
        n_na        = r_na;
        n_nb        = r_nb;
        n_sqa       = r_sqa;
        n_sqb       = r_sqb;
        n_den       = r_den;
        n_q         = r_q;
        n_zf        = r_zf;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_sim   = r_out_sim;
        n_out_zero  = r_out_zero;
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_a     = i_a_elem;
                    n_b     = i_b_elem;
                    n_last  = i_last;
                    n_state = S_MUL_AB;
                    n_go    = 1'b1;
                end
            end
            S_MUL_AB, S_MUL_AA, S_MUL_BB: begin
                if (fpu_stat.done) begin
                    n_p     = fpu_res;
                    n_state = r_state + 4'd1;
                    n_go    = 1'b1;
                end
            end
            S_ADD_DOT: begin
                if (fpu_stat.done) begin
                    n_dot   = fpu_res;
                    n_state = S_MUL_AA;
                    n_go    = 1'b1;
                end
            end
            S_ADD_NA: begin
                if (fpu_stat.done) begin
                    n_na    = fpu_res;
                    n_state = S_MUL_BB;
                    n_go    = 1'b1;
                end
            end
            S_ADD_NB: begin
                if (fpu_stat.done) begin
                    n_nb    = fpu_res;
                    n_state = r_last ? S_CHECK : S_IDLE;
                end
            end
            S_CHECK: begin
                if (f_is_zero(r_na) || f_is_zero(r_nb)) begin
                    n_q     = QNAN_BITS;
                    n_zf    = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_zf    = 1'b0;
                    n_state = S_SQ_A;
                    n_go    = 1'b1;
                end
            end
            S_SQ_A: begin
                if (ds_stat.done) begin
                    n_sqa   = ds_bits;
                    n_state = ds_special ? S_SQ_B : S_RND_A;
                    n_go    = 1'b1;
                end
            end
            S_RND_A: begin
                if (fpu_stat.done) begin
                    n_sqa   = fpu_res;
                    n_state = S_SQ_B;
                    n_go    = 1'b1;
                end
            end
            S_SQ_B: begin
                if (ds_stat.done) begin
                    n_sqb   = ds_bits;
                    n_state = ds_special ? S_MUL_DEN : S_RND_B;
                    n_go    = 1'b1;
                end
            end
            S_RND_B: begin
                if (fpu_stat.done) begin
                    n_sqb   = fpu_res;
                    n_state = S_MUL_DEN;
                    n_go    = 1'b1;
                end
            end
            S_MUL_DEN: begin
                if (fpu_stat.done) begin
                    n_den   = fpu_res;
                    n_state = S_DIV;
                    n_go    = 1'b1;
                end
            end
            S_DIV: begin
                if (ds_stat.done) begin
                    n_q     = ds_bits;
                    n_state = ds_special ? S_OUT : S_RND_Q;
                    n_go    = !ds_special;
                end
            end
            S_RND_Q: begin
                if (fpu_stat.done) begin
                    n_q     = fpu_res;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_sim   = r_q;
                    n_out_zero  = r_zf;
                    n_dot       = '0;
                    n_na        = '0;
                    n_nb        = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_dot       <= '0;
            r_na        <= '0;
            r_nb        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_go        <= n_go;
            r_dot       <= n_dot;
            r_na        <= n_na;
            r_nb        <= n_nb;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_last     <= n_last;
        r_p        <= n_p;
        r_sqa      <= n_sqa;
        r_sqb      <= n_sqb;
        r_den      <= n_den;
        r_q        <= n_q;
        r_zf       <= n_zf;
        r_out_sim  <= n_out_sim;
        r_out_zero <= n_out_zero;
    end

    assign o_out_valid  = r_out_valid;
    assign o_similarity = r_out_sim;
    assign o_zero_norm  = r_out_zero;

    `FCS_ASSERT_IMPLIES(a_fpu_start_idle, fpu_start, !fpu_stat.busy)
    `FCS_ASSERT_IMPLIES(a_dsu_start_idle, ds_start, !ds_stat.busy)
    `FCS_ASSERT_IMPLIES(a_zero_norm_nan, r_out_valid && r_out_zero, r_out_sim == QNAN_BITS)
    `FCS_ASSERT_NEXT(a_acc_clear, (r_state == S_OUT) && out_free, (r_dot | r_na | r_nb) == '0)

endmodule
